// ===== hdl/dbfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbfsd_pkg
// shared types and constants for the display bus frame snoop decoder
// ----------------------------------------------------------------------------
package dbfsd_pkg;

  localparam int FRAME_SLOTS_DEF = 14;

  localparam int TOL_W     = 27;
  localparam int MASK_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 27;

  localparam int UNIT_W   = 20;
  localparam int TOTAL_W  = 27;
  localparam int VOL_W    = 24;
  localparam int LITERS_W = 44;
  localparam int ERR_W    = 5;

  localparam int HI_W = 38;
  localparam int LO_W = 37;

  localparam logic [3:0] SLOT_FIRST = 4'h0;
  localparam logic [3:0] SLOT_LAST  = 4'hD;
  localparam logic [3:0] SLOT_TOTAL_END = 4'h7;
  localparam logic [3:0] SLOT_RUN   = 4'h8;
  localparam logic [3:0] SLOT_SECOND = 4'h1;
  localparam logic [3:0] SYM_L      = 4'hA;
  localparam logic [3:0] SYM_P      = 4'hC;
  localparam logic [3:0] DIGIT_ONE  = 4'h1;
  localparam logic [3:0] DIGIT_MAX  = 4'h9;
  localparam logic [7:0] EMPTY_BYTE = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_MASK  = 1'b1;

  localparam logic [ERR_W-1:0] ERR_INDEX = 5'b00001;
  localparam logic [ERR_W-1:0] ERR_UNIT  = 5'b00010;
  localparam logic [ERR_W-1:0] ERR_TOTAL = 5'b00100;
  localparam logic [ERR_W-1:0] ERR_VOL   = 5'b01000;
  localparam logic [ERR_W-1:0] ERR_GAP   = 5'b10000;

  localparam logic [TOL_W-1:0]  TOL_RESET  = 27'd100;
  localparam logic [MASK_W-1:0] MASK_RESET = 5'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic in_stall;
    logic scan_last;
    logic mul_en;
    logic out_load;
  } ctrl_t;

  function automatic logic [3:0] digit_of(input logic [7:0] b);
    logic [3:0] d;
    d = b[7:4];
    return (d > DIGIT_MAX) ? 4'd0 : d;
  endfunction

endpackage

// ===== hdl/display_bus_frame_snoop_decoder_core.sv =====
// ----------------------------------------------------------------------------
// display_bus_frame_snoop_decoder_core
// snoops a two-line display bus, files latched bytes into frame stores and
// decodes a completed frame into prices, volume or totaliser value
// ----------------------------------------------------------------------------
// sequence: shift and latch beats are accepted while idle; a frame-ending latch
// beat starts a slot scan through the frame stores, then a multiply step and a
// finish step that loads the result registers, waiting while a held result stalls
// throughput: one beat per cycle while idle; input stalls during the scan,
// multiply and finish steps of each completed frame
// reset: synchronous active low; shift bytes cleared, stores read as 0xFF,
// tolerance 100, error mask 31
module display_bus_frame_snoop_decoder_core
  import dbfsd_pkg::*;
#(
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic                 in_line_a_bit,
  input  logic                 in_line_b_bit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [UNIT_W-1:0]    out_unit_price,
  output logic [TOTAL_W-1:0]   out_total_price,
  output logic [VOL_W-1:0]     out_volume,
  output logic [LITERS_W-1:0]  out_total_liters,
  output logic                 out_totaliser_mode,
  output logic                 out_select_l_shown,
  output logic                 out_select_p_shown,
  output logic                 out_running,
  output logic [ERR_W-1:0]     out_error_flags,
  output logic                 out_accepted
);

  localparam int SLOT_W = $clog2(FRAME_SLOTS);

  state_t state_r, state_nxt;
  ctrl_t  ctrl;

  logic [SLOT_W-1:0]      slot_r;
  logic [7:0]             shift_a_r, shift_b_r;
  logic                   started_r;
  logic [FRAME_SLOTS-1:0] valid_a_r, valid_b_r;
  logic [7:0]             store_a_r [FRAME_SLOTS];
  logic [7:0]             store_b_r [FRAME_SLOTS];
  logic [TOL_W-1:0]       tol_r;
  logic [MASK_W-1:0]      mask_r;

  logic [TOTAL_W-1:0]  acc_total_r;
  logic [UNIT_W-1:0]   acc_unit_r;
  logic [VOL_W-1:0]    acc_vol_r;
  logic [LITERS_W-1:0] acc_lit_r;
  logic [ERR_W-1:0]    err_r;
  logic                l0_r, l1_r, p0_r, run_r;
  logic [LITERS_W-1:0] prod_r;
  logic [HI_W-1:0]     hi_r;
  logic [LO_W-1:0]     lo_r;
  logic                lo_ok_r;

  logic                out_valid_r;
  logic [UNIT_W-1:0]   out_unit_r;
  logic [TOTAL_W-1:0]  out_total_r;
  logic [VOL_W-1:0]    out_vol_r;
  logic [LITERS_W-1:0] out_lit_r;
  logic                out_tot_r, out_l_r, out_p_r, out_run_r, out_acc_r;
  logic [ERR_W-1:0]    out_err_r;

  logic        in_acc;
  logic [3:0]  ia, ib;
  logic        frame_end;
  logic [3:0]  slot4;
  logic [7:0]  rd_a, rd_b;
  logic [3:0]  da, db;
  logic        in_total_span, in_vol_span;
  logic [ERR_W-1:0] err_nxt;

  logic [LITERS_W-1:0] prod_nxt;
  logic [27:0]         hi_sum;
  logic [HI_W-1:0]     hi_nxt;
  logic [TOL_W-1:0]    lo_diff;
  logic [LO_W-1:0]     lo_nxt;

  logic             tot;
  logic             gap_err;
  logic [ERR_W-1:0] flags;

  assign in_acc    = in_valid && !ctrl.in_stall;
  assign ia        = shift_a_r[3:0];
  assign ib        = shift_b_r[3:0];
  assign frame_end = in_acc && in_command && (ia == SLOT_LAST) && started_r;

  // slot scan read
  assign slot4 = 4'(slot_r);
  assign rd_a  = valid_a_r[slot_r] ? store_a_r[slot_r] : EMPTY_BYTE;
  assign rd_b  = valid_b_r[slot_r] ? store_b_r[slot_r] : EMPTY_BYTE;
  assign da    = digit_of(rd_a);
  assign db    = digit_of(rd_b);
  assign in_total_span = (slot4 <= SLOT_TOTAL_END);
  assign in_vol_span   = (slot4 >= SLOT_SECOND) && (slot4 <= SLOT_TOTAL_END);

  always_comb begin
    err_nxt = err_r;
    if (rd_a[3:0] != slot4) begin
      err_nxt = err_nxt | ERR_INDEX | (in_total_span ? ERR_TOTAL : ERR_UNIT);
    end
    if (in_vol_span && (rd_b[3:0] != slot4)) begin
      err_nxt = err_nxt | ERR_INDEX | ERR_VOL;
    end
  end

  // price gap bounds: floor(p/1000) > t  <=>  p >= 1000*(t+1)
  assign prod_nxt = acc_unit_r * acc_vol_r;
  assign hi_sum   = 28'(acc_total_r) + 28'(tol_r) + 28'd1;
  assign hi_nxt   = HI_W'(hi_sum) * HI_W'(1000);
  assign lo_diff  = acc_total_r - tol_r;
  assign lo_nxt   = LO_W'(lo_diff) * LO_W'(1000);

  assign tot     = l0_r && l1_r;
  assign gap_err = !tot && ((prod_r >= LITERS_W'(hi_r)) ||
                            (lo_ok_r && (prod_r < LITERS_W'(lo_r))));
  assign flags   = err_r | (gap_err ? ERR_GAP : '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (frame_end) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (slot4 == SLOT_LAST) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE: ctrl.in_stall = 1'b0;
      ST_SCAN: begin
        ctrl.in_stall  = 1'b1;
        ctrl.scan_last = (slot4 == SLOT_LAST);
      end
      ST_MUL: begin
        ctrl.in_stall = 1'b1;
        ctrl.mul_en   = 1'b1;
      end
      ST_FIN: begin
        ctrl.in_stall = 1'b1;
        ctrl.out_load = !out_valid_r || !out_stall;
      end
      default: ctrl.in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      shift_a_r   <= '0;
      shift_b_r   <= '0;
      started_r   <= 1'b0;
      valid_a_r   <= '0;
      valid_b_r   <= '0;
      tol_r       <= TOL_RESET;
      mask_r      <= MASK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_TOLERANCE: tol_r  <= cfg_wdata[TOL_W-1:0];
          REG_ERR_MASK:  mask_r <= cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        if (!in_command) begin
          shift_a_r <= {shift_a_r[6:0], in_line_a_bit};
          shift_b_r <= {shift_b_r[6:0], in_line_b_bit};
        end else begin
          shift_a_r <= '0;
          shift_b_r <= '0;
          if (ia == SLOT_FIRST) started_r <= 1'b1;
          if ((ia <= SLOT_LAST) && ((ia == SLOT_FIRST) || started_r)) begin
            valid_a_r[ia[SLOT_W-1:0]] <= 1'b1;
            if (32'(ib) < FRAME_SLOTS) valid_b_r[ib[SLOT_W-1:0]] <= 1'b1;
          end
        end
      end

      if (frame_end) slot_r <= '0;
      else if (state_r == ST_SCAN) slot_r <= slot_r + 1'b1;

      // re-arm once the scan has read every slot
      if (ctrl.scan_last) begin
        started_r <= 1'b0;
        valid_a_r <= '0;
        valid_b_r <= '0;
      end

      if (ctrl.out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // frame stores and decode datapath
  always_ff @(posedge clk) begin
    if (in_acc && in_command && (ia <= SLOT_LAST) && ((ia == SLOT_FIRST) || started_r)) begin
      store_a_r[ia[SLOT_W-1:0]] <= shift_a_r;
      if (32'(ib) < FRAME_SLOTS) store_b_r[ib[SLOT_W-1:0]] <= shift_b_r;
    end

    if (frame_end) begin
      acc_total_r <= '0;
      acc_unit_r  <= '0;
      acc_vol_r   <= '0;
      acc_lit_r   <= '0;
      err_r       <= '0;
    end else if (state_r == ST_SCAN) begin
      err_r <= err_nxt;
      if (in_total_span) begin
        acc_total_r <= TOTAL_W'(acc_total_r * TOTAL_W'(10) + TOTAL_W'(da));
      end else begin
        acc_unit_r <= UNIT_W'(acc_unit_r * UNIT_W'(10) + UNIT_W'(da));
      end
      if (in_vol_span) begin
        acc_vol_r <= VOL_W'(acc_vol_r * VOL_W'(10) + VOL_W'(db));
        acc_lit_r <= LITERS_W'(acc_lit_r * LITERS_W'(10) + LITERS_W'(db));
      end else if (!in_total_span) begin
        acc_lit_r <= LITERS_W'(acc_lit_r * LITERS_W'(10) + LITERS_W'(da));
      end
      if (slot4 == SLOT_FIRST) begin
        l0_r <= (rd_a[7:4] == SYM_L);
        p0_r <= (rd_b[7:4] == SYM_P);
      end
      if (slot4 == SLOT_SECOND) l1_r  <= (rd_a[7:4] == SYM_L);
      if (slot4 == SLOT_RUN)    run_r <= (rd_b[7:4] == DIGIT_ONE);
    end

    if (ctrl.mul_en) begin
      prod_r  <= prod_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
      lo_ok_r <= (acc_total_r > tol_r);
    end

    if (ctrl.out_load) begin
      out_unit_r  <= tot ? '0 : acc_unit_r;
      out_total_r <= tot ? '0 : acc_total_r;
      out_vol_r   <= tot ? '0 : acc_vol_r;
      out_lit_r   <= tot ? acc_lit_r : '0;
      out_tot_r   <= tot;
      out_l_r     <= l0_r;
      out_p_r     <= p0_r;
      out_run_r   <= run_r;
      out_err_r   <= flags;
      out_acc_r   <= ((flags & mask_r) == '0);
    end
  end

  assign in_stall           = ctrl.in_stall;
  assign out_valid          = out_valid_r;
  assign out_unit_price     = out_unit_r;
  assign out_total_price    = out_total_r;
  assign out_volume         = out_vol_r;
  assign out_total_liters   = out_lit_r;
  assign out_totaliser_mode = out_tot_r;
  assign out_select_l_shown = out_l_r;
  assign out_select_p_shown = out_p_r;
  assign out_running        = out_run_r;
  assign out_error_flags    = out_err_r;
  assign out_accepted       = out_acc_r;

`ifndef SYNTHESIS
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result beat raised outside finish step");

  a_rearmed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> !started_r && valid_a_r == '0 && valid_b_r == '0)
    else $error("frame stores not re-armed after scan");

  a_mode_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tot_r ? (out_unit_r == '0 && out_total_r == '0 &&
      out_vol_r == '0 && !out_err_r[4]) : out_lit_r == '0))
    else $error("mode fields inconsistent");
`endif

endmodule
